@@ rtl/manchester_frame_transmitter_defines.svh @@
// Assertion macros for the Manchester frame transmitter.
// Uses i_clk and i_rst_n of the module that includes this header.
`ifndef MANCHESTER_FRAME_TRANSMITTER_DEFINES_SVH
`define MANCHESTER_FRAME_TRANSMITTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define MFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define MFT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define MFT_ASSERT(label, prop, msg)
`define MFT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ rtl/mft_pkg.sv @@
// Shared types and codes for the Manchester frame transmitter.
// No dependencies.
`default_nettype none
package mft_pkg;

    // symbol kind codes
    localparam logic [1:0] KIND_PREAMBLE = 2'd0;
    localparam logic [1:0] KIND_START    = 2'd1;
    localparam logic [1:0] KIND_DATA     = 2'd2;
    localparam logic [1:0] KIND_TAIL     = 2'd3;

    // sequencer phase codes
    localparam logic [1:0] PH_PRE   = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_TAIL  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_SYNC     = 2'd0;
    localparam logic [1:0] REG_PREAMBLE = 2'd1;
    localparam logic [1:0] REG_WHITEN   = 2'd2;

    localparam logic [7:0] WHITEN_RESET   = 8'hCA;
    localparam logic [4:0] PREAMBLE_RESET = 5'd3;
    localparam logic [2:0] DATA_LAST_IDX  = 3'd7;
    localparam logic [4:0] TAIL_LAST_IDX  = 5'd2;

    // one buffered frame byte, already whitened
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_item;

    // one line symbol
    typedef struct packed {
        logic       bit_val;
        logic [1:0] kind;
        logic       first_lvl;
        logic       second_lvl;
        logic       frame_end;
        logic       last_in_run;
    } t_sym;

endpackage
`default_nettype wire

@@ rtl/mft_seq.sv @@
// Symbol sequencer: walks preamble, start, data and tail symbols of one byte, as its first and last flags select.
// Depends on mft_pkg and manchester_frame_transmitter_defines.svh.
`default_nettype none
`include "manchester_frame_transmitter_defines.svh"
module mft_seq (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_sync,
    input  wire [4:0]      i_pre_cnt,
    input  wire            i_item_valid,
    input  mft_pkg::t_item i_item,
    output logic           o_item_ready,
    output logic           o_sym_valid,
    output mft_pkg::t_sym  o_sym,
    input  wire            i_sym_ready
);

    logic           r_busy;
    logic [1:0]     r_phase;
    logic [4:0]     r_cnt;
    mft_pkg::t_item r_item;
    logic           r_line;
    mft_pkg::t_sym  r_out;
    logic           r_out_valid;

    logic           emit;
    logic           load;
    mft_pkg::t_sym  sym;
    logic           pre_done;
    logic [1:0]     n_phase;
    logic [4:0]     n_cnt;
    logic           n_busy;

    assign emit         = r_busy && (!r_out_valid || i_sym_ready);
    assign o_item_ready = !r_busy || (emit && sym.last_in_run);
    assign load         = i_item_valid && o_item_ready;
    assign pre_done     = ({1'b0, r_cnt} + 6'd1) == {1'b0, i_pre_cnt};

    // current symbol
    always_comb begin
        sym = '0;
        sym.first_lvl = r_line;
        unique case (r_phase)
            mft_pkg::PH_PRE: begin
                sym.bit_val = i_sync;
                sym.kind    = mft_pkg::KIND_PREAMBLE;
            end
            mft_pkg::PH_START: begin
                sym.bit_val = ~i_sync;
                sym.kind    = mft_pkg::KIND_START;
            end
            mft_pkg::PH_DATA: begin
                sym.bit_val     = r_item.data[r_cnt[2:0]];
                sym.kind        = mft_pkg::KIND_DATA;
                sym.last_in_run = (r_cnt[2:0] == mft_pkg::DATA_LAST_IDX) && !r_item.last;
            end
            default: begin
                sym.bit_val     = i_sync;
                sym.kind        = mft_pkg::KIND_TAIL;
                sym.frame_end   = (r_cnt == mft_pkg::TAIL_LAST_IDX);
                sym.last_in_run = (r_cnt == mft_pkg::TAIL_LAST_IDX);
            end
        endcase
        sym.second_lvl = ~sym.bit_val;
    end

    // next phase and count
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        if (emit) begin
            unique case (r_phase)
                mft_pkg::PH_PRE: begin
                    if (pre_done) begin
                        n_phase = mft_pkg::PH_START;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
                mft_pkg::PH_START: begin
                    n_phase = mft_pkg::PH_DATA;
                    n_cnt   = '0;
                end
                mft_pkg::PH_DATA: begin
                    if (r_cnt[2:0] == mft_pkg::DATA_LAST_IDX) begin
                        n_phase = mft_pkg::PH_TAIL;
                        n_cnt   = '0;
                        n_busy  = r_item.last;
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
                default: begin
                    if (r_cnt == mft_pkg::TAIL_LAST_IDX) begin
                        n_busy = 1'b0;
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
            endcase
        end
        // a new byte picks its starting phase
        if (load) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            if (!i_item.first) begin
                n_phase = mft_pkg::PH_DATA;
            end else if (i_pre_cnt == 5'd0) begin
                n_phase = mft_pkg::PH_START;
            end else begin
                n_phase = mft_pkg::PH_PRE;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= mft_pkg::PH_DATA;
            r_cnt       <= '0;
            r_line      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            if (emit) begin
                r_line      <= sym.bit_val;
                r_out_valid <= 1'b1;
            end else if (i_sym_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
        if (emit) begin
            r_out <= sym;
        end
    end

    assign o_sym_valid = r_out_valid;
    assign o_sym       = r_out;

    `MFT_ASSERT(a_fend_tail, r_out_valid && r_out.frame_end |-> r_out.last_in_run && r_out.kind == mft_pkg::KIND_TAIL, "frame end off a final tail symbol")
    `MFT_ASSERT(a_run_continues, emit && !sym.last_in_run |=> r_busy, "sequencer stopped inside a run")
    `MFT_ASSERT(a_data_cnt, r_busy && r_phase == mft_pkg::PH_DATA |-> r_cnt < 5'd8, "data bit index out of range")
    `MFT_ASSERT_ALWAYS(a_levels, r_out_valid |-> r_out.second_lvl != r_out.bit_val, "second part level not inverse of bit")

endmodule
`default_nettype wire

@@ rtl/manchester_frame_transmitter.sv @@
// Manchester frame transmitter: frame bytes in, line symbols out. Uses mft_pkg and mft_seq.
// The first symbol of a byte passes through the input buffer, the sequencer state and the output register.
// Throughput: one symbol per cycle while the output is ready; a byte gives 8 data symbols, plus
// preamble_count preamble symbols and one start symbol with first set, and 3 tail symbols with last set.
// A one-beat input buffer lets the next byte follow the last symbol without a gap.
// Reset (synchronous, active low) clears control and line level, registers to defaults.
`default_nettype none
module manchester_frame_transmitter (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // config write port
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_addr,
    input  wire [7:0]  i_cfg_data,
    // byte input
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire        i_s_axis_tuser,   // [0] first_byte
    input  wire        i_s_axis_tlast,   // last_byte
    // symbol output
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [0] symbol_bit, [1] first_part_level,
                                         // [2] second_part_level, [3] frame_end, [7:4] 0
    output logic [1:0] o_m_axis_tuser,   // [1:0] symbol_kind
    output logic       o_m_axis_tlast    // last_in_run
);

    logic           r_sync;
    logic [4:0]     r_pre_cnt;
    logic [7:0]     r_whiten;
    logic           r_buf_valid;
    mft_pkg::t_item r_buf;

    logic           item_ready;
    logic           in_beat;
    logic           sym_valid;
    mft_pkg::t_sym  sym;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync    <= 1'b0;
            r_pre_cnt <= mft_pkg::PREAMBLE_RESET;
            r_whiten  <= mft_pkg::WHITEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mft_pkg::REG_SYNC:     r_sync    <= i_cfg_data[0];
                mft_pkg::REG_PREAMBLE: r_pre_cnt <= i_cfg_data[4:0];
                mft_pkg::REG_WHITEN:   r_whiten  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input buffer, byte stored whitened
    assign o_s_axis_tready = !r_buf_valid || item_ready;
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= 1'b0;
        end else if (in_beat) begin
            r_buf_valid <= 1'b1;
        end else if (item_ready) begin
            r_buf_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_buf.data  <= i_s_axis_tdata ^ r_whiten;
            r_buf.first <= i_s_axis_tuser;
            r_buf.last  <= i_s_axis_tlast;
        end
    end

    mft_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sync       (r_sync),
        .i_pre_cnt    (r_pre_cnt),
        .i_item_valid (r_buf_valid),
        .i_item       (r_buf),
        .o_item_ready (item_ready),
        .o_sym_valid  (sym_valid),
        .o_sym        (sym),
        .i_sym_ready  (i_m_axis_tready)
    );

    // output packing
    assign o_m_axis_tvalid = sym_valid;
    assign o_m_axis_tdata  = {4'b0000, sym.frame_end, sym.second_lvl, sym.first_lvl, sym.bit_val};
    assign o_m_axis_tuser  = sym.kind;
    assign o_m_axis_tlast  = sym.last_in_run;

endmodule
`default_nettype wire
